/* rtl/core/gha_pkg.sv */
package gha_pkg;

   localparam int SLOTS_DEFAULT = 64;

   localparam logic [31:0] REGION_BASE_RESET = 32'h0000_0000;
   localparam logic [31:0] REGION_SIZE_RESET = 32'h0001_0000;

   localparam logic [31:0] NONE_HANDLE = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_EMPTY     = 3'd1,
      ERR_NOT_FOUND = 3'd2,
      ERR_TOO_MANY  = 3'd3,
      ERR_NEGATIVE  = 3'd4,
      ERR_STALE     = 3'd5
   } err_type;

   typedef enum logic [0:0] {
      CSR_REGION_BASE = 1'b0,
      CSR_REGION_SIZE = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_RING_RD,
      ST_SLOT_RD,
      ST_REGION
   } state_type;

   typedef struct packed {
      logic        start;
      logic [31:0] value;
   } mod_req_type;

endpackage

/* rtl/core/generational_handle_allocator.sv */
// Channel    Ports                                   Handshake
// request    req_opcode, req_handle_in               start & !busy
// response   rsp_ok, rsp_error_code, rsp_handle_out,  rsp_valid, one-cycle strobe
//            rsp_slot_index, rsp_region_start/end
// config     csr_index, csr_data                     csr_we, written at once
//
// One transaction at a time. Allocate goes through the free-ring read, then the
// slot's generation/handle read, then region multiply and add. Successful free
// and lookup first wait for the remainder (low bits for power-of-two SLOTS,
// reciprocal multiply and subtract otherwise), then read the slot and compute
// the region; a stale or unknown handle answers from the slot read. Early
// rejects answer straight from idle. After reset a clearing pass over every
// slot fills the ring and the slot table; busy stays high meanwhile. The
// receiver cannot stall: each result is a single-cycle strobe.
module generational_handle_allocator #(
   parameter int SLOTS = gha_pkg::SLOTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic signed [31:0] req_handle_in,
   output logic               rsp_valid,
   output logic               rsp_ok,
   output logic [2:0]         rsp_error_code,
   output logic signed [31:0] rsp_handle_out,
   output logic [5:0]         rsp_slot_index,
   output logic [31:0]        rsp_region_start,
   output logic [31:0]        rsp_region_end,
   input  logic               csr_we,
   input  logic [0:0]         csr_index,
   input  logic [31:0]        csr_data
);

   localparam int IDX_W   = $clog2(SLOTS);
   localparam int CNT_W   = IDX_W + 1;
   localparam int MAX_GEN = 2147483647 / SLOTS;
   localparam int GEN_W   = $clog2(MAX_GEN + 1);
   localparam int SW      = GEN_W + 32;

   localparam logic [CNT_W-1:0] SLOTS_C   = CNT_W'(SLOTS);
   localparam logic [CNT_W-1:0] RING_LAST = CNT_W'(2 * SLOTS - 1);
   localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(SLOTS - 1);
   localparam logic [GEN_W-1:0] GEN_LAST  = GEN_W'(MAX_GEN);
   localparam logic [31:0]      SLOTS_W   = 32'(SLOTS);

   // state
   gha_pkg::state_type state_ff, state_in;
   gha_pkg::op_type    op_ff, op_in;
   logic [31:0]        h_ff, h_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;
   logic [CNT_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   tail_ff, tail_in;
   logic [31:0]        prod_ff, prod_in;
   logic [31:0]        region_base_ff;
   logic [31:0]        region_size_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff, rsp_ok_in;
   gha_pkg::err_type   rsp_err_ff, rsp_err_in;
   logic [31:0]        rsp_handle_ff, rsp_handle_in;
   logic [5:0]         rsp_slot_ff, rsp_slot_in;
   logic [31:0]        rsp_start_ff, rsp_start_in;
   logic [31:0]        rsp_end_ff, rsp_end_in;

   // memories
   logic [IDX_W-1:0]   ring_ram [SLOTS];
   logic [SW-1:0]      slot_ram [SLOTS];
   logic [IDX_W-1:0]   ring_rdata_ff;
   logic [SW-1:0]      slot_rdata_ff;
   logic               ring_we;
   logic [IDX_W-1:0]   ring_waddr;
   logic [IDX_W-1:0]   ring_wdata;
   logic [IDX_W-1:0]   ring_raddr;
   logic               slot_we;
   logic [IDX_W-1:0]   slot_waddr;
   logic [SW-1:0]      slot_wdata;
   logic [IDX_W-1:0]   slot_raddr;

   gha_pkg::mod_req_type mod_req;
   logic                 mod_done;
   logic [IDX_W-1:0]     mod_rem;

   logic [IDX_W-1:0]   head_idx;
   logic [IDX_W-1:0]   tail_idx;
   logic [CNT_W:0]     ring_count;
   logic               ring_empty;
   logic               ring_full;
   logic               accept;

   gha_mod #(
      .SLOTS(SLOTS)
   ) u_mod (
      .clock(clock),
      .reset(reset),
      .req  (mod_req),
      .done (mod_done),
      .rem  (mod_rem)
   );

   assign accept = start && (state_ff == gha_pkg::ST_IDLE);
   assign busy   = (state_ff != gha_pkg::ST_IDLE);

   assign head_idx = (head_ff >= SLOTS_C) ? IDX_W'(head_ff - SLOTS_C) : IDX_W'(head_ff);
   assign tail_idx = (tail_ff >= SLOTS_C) ? IDX_W'(tail_ff - SLOTS_C) : IDX_W'(tail_ff);
   assign ring_count = (tail_ff >= head_ff) ? ({1'b0, tail_ff} - {1'b0, head_ff})
                     : ({1'b0, tail_ff} + (CNT_W + 1)'(2 * SLOTS) - {1'b0, head_ff});
   assign ring_empty = (head_ff == tail_ff);
   assign ring_full  = (ring_count == (CNT_W + 1)'(SLOTS));
   assign ring_raddr = head_idx;

   always_comb begin
      logic [GEN_W-1:0] gen;
      logic [31:0]      stored;
      logic [31:0]      new_handle;
      gen        = slot_rdata_ff[SW-1:32];
      stored     = slot_rdata_ff[31:0];
      new_handle = ({{(32 - GEN_W){1'b0}}, gen} * SLOTS_W) + 32'(slot_ff);

      state_in      = state_ff;
      op_in         = op_ff;
      h_in          = h_ff;
      slot_in       = slot_ff;
      clr_in        = clr_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = 1'b0;
      rsp_ok_in     = rsp_ok_ff;
      rsp_err_in    = rsp_err_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_end_in    = rsp_end_ff;
      ring_we       = 1'b0;
      ring_waddr    = tail_idx;
      ring_wdata    = slot_ff;
      slot_we       = 1'b0;
      slot_waddr    = slot_ff;
      slot_wdata    = {gen, gha_pkg::NONE_HANDLE};
      slot_raddr    = slot_ff;
      mod_req.start = 1'b0;
      mod_req.value = req_handle_in;

      // failure response defaults; error code set per case
      if (state_ff == gha_pkg::ST_IDLE || state_ff == gha_pkg::ST_SLOT_RD) begin
         rsp_ok_in     = 1'b0;
         rsp_handle_in = gha_pkg::NONE_HANDLE;
         rsp_slot_in   = '0;
         rsp_start_in  = '0;
         rsp_end_in    = '0;
      end

      case (state_ff)
         gha_pkg::ST_CLEAR: begin
            ring_we    = 1'b1;
            ring_waddr = clr_ff;
            ring_wdata = clr_ff;
            slot_we    = 1'b1;
            slot_waddr = clr_ff;
            slot_wdata = {{GEN_W{1'b0}}, gha_pkg::NONE_HANDLE};
            if (clr_ff == IDX_LAST) begin
               state_in = gha_pkg::ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         gha_pkg::ST_IDLE: begin
            if (start) begin
               op_in = gha_pkg::op_type'(req_opcode);
               h_in  = req_handle_in;
               case (gha_pkg::op_type'(req_opcode))
                  gha_pkg::OP_ALLOC: begin
                     if (ring_empty) begin
                        rsp_valid_in = 1'b1;
                        rsp_err_in   = gha_pkg::ERR_EMPTY;
                     end else begin
                        state_in = gha_pkg::ST_RING_RD;
                     end
                  end
                  gha_pkg::OP_FREE: begin
                     if (ring_full) begin
                        rsp_valid_in = 1'b1;
                        rsp_err_in   = gha_pkg::ERR_TOO_MANY;
                     end else if (req_handle_in[31]) begin
                        rsp_valid_in = 1'b1;
                        rsp_err_in   = gha_pkg::ERR_NEGATIVE;
                     end else begin
                        mod_req.start = 1'b1;
                        state_in      = gha_pkg::ST_MOD;
                     end
                  end
                  gha_pkg::OP_LOOKUP: begin
                     if (req_handle_in[31]) begin
                        rsp_valid_in = 1'b1;
                        rsp_err_in   = gha_pkg::ERR_NOT_FOUND;
                     end else begin
                        mod_req.start = 1'b1;
                        state_in      = gha_pkg::ST_MOD;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_err_in   = gha_pkg::ERR_NONE;
                  end
               endcase
            end
         end
         gha_pkg::ST_RING_RD: begin
            slot_in    = ring_rdata_ff;
            slot_raddr = ring_rdata_ff;
            state_in   = gha_pkg::ST_SLOT_RD;
         end
         gha_pkg::ST_MOD: begin
            slot_raddr = mod_rem;
            if (mod_done) begin
               slot_in  = mod_rem;
               state_in = gha_pkg::ST_SLOT_RD;
            end
         end
         gha_pkg::ST_SLOT_RD: begin
            prod_in = 32'(slot_ff) * region_size_ff;
            if (op_ff == gha_pkg::OP_ALLOC) begin
               h_in       = new_handle;
               slot_we    = 1'b1;
               slot_wdata = {(gen >= GEN_LAST) ? {GEN_W{1'b0}} : gen + 1'b1, new_handle};
               head_in    = (head_ff == RING_LAST) ? '0 : head_ff + 1'b1;
               state_in   = gha_pkg::ST_REGION;
            end else if (stored != h_ff) begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = (op_ff == gha_pkg::OP_FREE) ? gha_pkg::ERR_STALE
                                                          : gha_pkg::ERR_NOT_FOUND;
               state_in     = gha_pkg::ST_IDLE;
            end else begin
               if (op_ff == gha_pkg::OP_FREE) begin
                  ring_we = 1'b1;
                  slot_we = 1'b1;
                  tail_in = (tail_ff == RING_LAST) ? '0 : tail_ff + 1'b1;
               end
               state_in = gha_pkg::ST_REGION;
            end
         end
         gha_pkg::ST_REGION: begin
            rsp_valid_in  = 1'b1;
            rsp_ok_in     = 1'b1;
            rsp_err_in    = gha_pkg::ERR_NONE;
            rsp_handle_in = h_ff;
            rsp_slot_in   = 6'(slot_ff);
            rsp_start_in  = region_base_ff + prod_ff;
            rsp_end_in    = region_base_ff + prod_ff + region_size_ff;
            state_in      = gha_pkg::ST_IDLE;
         end
         default: begin
            state_in = gha_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gha_pkg::ST_CLEAR;
         clr_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= SLOTS_C;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      h_ff          <= h_in;
      slot_ff       <= slot_in;
      prod_ff       <= prod_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_err_ff    <= rsp_err_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_end_ff    <= rsp_end_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_base_ff <= gha_pkg::REGION_BASE_RESET;
         region_size_ff <= gha_pkg::REGION_SIZE_RESET;
      end else if (csr_we) begin
         case (gha_pkg::csr_index_type'(csr_index))
            gha_pkg::CSR_REGION_BASE: region_base_ff <= csr_data;
            gha_pkg::CSR_REGION_SIZE: region_size_ff <= csr_data;
            default: region_base_ff <= region_base_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_ram[ring_waddr] <= ring_wdata;
      end
      ring_rdata_ff <= ring_ram[ring_raddr];
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_ram[slot_waddr] <= slot_wdata;
      end
      slot_rdata_ff <= slot_ram[slot_raddr];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_error_code   = rsp_err_ff;
   assign rsp_handle_out   = rsp_handle_ff;
   assign rsp_slot_index   = rsp_slot_ff;
   assign rsp_region_start = rsp_start_ff;
   assign rsp_region_end   = rsp_end_ff;

   a_ring_count_bound: assert property (@(posedge clock) disable iff (reset)
      ring_count <= (CNT_W + 1)'(SLOTS))
      else $error("free ring holds more than SLOTS entries");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == gha_pkg::ST_REGION) || $past(accept)
                 || ($past(state_ff) == gha_pkg::ST_SLOT_RD))
      else $error("response without a transaction behind it");

   a_head_moves_on_alloc: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && head_ff != $past(head_ff))
         |-> ($past(state_ff) == gha_pkg::ST_SLOT_RD && $past(op_ff) == gha_pkg::OP_ALLOC))
      else $error("ring head moved outside an allocate");

   a_mod_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> state_ff == gha_pkg::ST_MOD)
      else $error("remainder finished outside its wait state");

   a_fail_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_handle_out == -32'sd1 && rsp_slot_index == 6'd0
                                  && rsp_region_start == 32'd0))
      else $error("failed transaction carries slot data");

endmodule

/* rtl/core/gha_mod.sv */
// Remainder of a 32-bit value by SLOTS. Power-of-two sizes register the low
// bits; other sizes register the quotient from a fixed-point reciprocal
// multiply, then register the subtracted remainder.
module gha_mod #(
   parameter int SLOTS = gha_pkg::SLOTS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  gha_pkg::mod_req_type       req,
   output logic                       done,
   output logic [$clog2(SLOTS)-1:0]   rem
);

   localparam int IDX_W = $clog2(SLOTS);

   generate
      if ((SLOTS & (SLOTS - 1)) == 0) begin : g_pow2
         logic             done_ff;
         logic [IDX_W-1:0] rem_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= req.start;
            end
            if (req.start) begin
               rem_ff <= req.value[IDX_W-1:0];
            end
         end

         assign done = done_ff;
         assign rem  = rem_ff;
      end else begin : g_recip
         localparam int               SH      = 32 + IDX_W;
         localparam logic [32:0]      RECIP   = 33'(((64'd1 << SH) / 64'(SLOTS)) + 64'd1);
         localparam logic [IDX_W-1:0] DIVISOR = IDX_W'(SLOTS);

         logic             run_ff;
         logic             done_ff;
         logic [IDX_W-1:0] low_ff;
         logic [31:0]      quot_ff;
         logic [IDX_W-1:0] rem_ff;
         logic [64:0]      prod;
         logic [31:0]      quot_in;
         logic [IDX_W-1:0] rem_in;

         // exact quotient for every 32-bit value; the remainder is below
         // 2^IDX_W, so only the low bits of the back-multiply matter
         assign prod    = {33'd0, req.value} * {32'd0, RECIP};
         assign quot_in = 32'(prod >> SH);
         assign rem_in  = low_ff - quot_ff[IDX_W-1:0] * DIVISOR;

         always_ff @(posedge clock) begin
            if (reset) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b0;
            end else begin
               run_ff  <= req.start;
               done_ff <= run_ff;
            end
            if (req.start) begin
               low_ff  <= req.value[IDX_W-1:0];
               quot_ff <= quot_in;
            end
            if (run_ff) begin
               rem_ff <= rem_in;
            end
         end

         assign done = done_ff;
         assign rem  = rem_ff;
      end
   endgenerate

endmodule

/* tb/gha_result_checker.sv */
`timescale 1ns / 100ps

module gha_result_checker
   import gha_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic signed [31:0] req_handle_in,
   input  logic               rsp_valid,
   input  logic               rsp_ok,
   input  logic [2:0]         rsp_error_code,
   input  logic signed [31:0] rsp_handle_out,
   input  logic [5:0]         rsp_slot_index,
   input  logic [31:0]        rsp_region_start,
   input  logic [31:0]        rsp_region_end,
   input  logic               csr_we,
   input  logic [0:0]         csr_index,
   input  logic [31:0]        csr_data,
   output int unsigned        fault_count,
   output int unsigned        outstanding
);

   localparam int SLOTS = SLOTS_DEFAULT;

   typedef struct packed {
      logic        ok;
      logic [2:0]  error_code;
      logic [31:0] handle;
      logic [5:0]  slot;
      logic [31:0] region_start;
      logic [31:0] region_end;
   } outcome_t;

   logic [31:0] base_q;
   logic [31:0] size_q;
   logic [5:0]  ring_q  [SLOTS];
   logic [24:0] gen_q   [SLOTS];
   logic [31:0] owner_q [SLOTS];
   logic [6:0]  head_q;
   logic [6:0]  tail_q;
   outcome_t    pending_outcomes [$];

   function automatic outcome_t granted(logic [31:0] handle, logic [5:0] slot);
      outcome_t r;
      r.ok           = 1'b1;
      r.error_code   = ERR_NONE;
      r.handle       = handle;
      r.slot         = slot;
      r.region_start = base_q + {26'd0, slot} * size_q;
      r.region_end   = r.region_start + size_q;
      return r;
   endfunction

   function automatic outcome_t refused(err_type code);
      outcome_t r;
      r            = '0;
      r.error_code = code;
      r.handle     = NONE_HANDLE;
      return r;
   endfunction

   // advances the slot table and ring exactly as one accepted transaction does
   function automatic outcome_t apply_request(op_type op, logic [31:0] h);
      logic [5:0]  s;
      logic [24:0] g;
      logic [6:0]  ring_used;
      s         = h[5:0];
      ring_used = tail_q - head_q;
      case (op)
         OP_ALLOC: begin
            if (head_q == tail_q)
               return refused(ERR_EMPTY);
            s = ring_q[head_q[5:0]];
            g = gen_q[s];
            owner_q[s] = {1'b0, g, s};
            gen_q[s]   = g + 25'd1;   // top generation wraps to zero
            head_q     = head_q + 7'd1;
            return granted({1'b0, g, s}, s);
         end
         OP_FREE: begin
            if (ring_used == 7'd64)
               return refused(ERR_TOO_MANY);
            if (h[31])
               return refused(ERR_NEGATIVE);
            if (owner_q[s] != h)
               return refused(ERR_STALE);
            ring_q[tail_q[5:0]] = s;
            tail_q     = tail_q + 7'd1;
            owner_q[s] = NONE_HANDLE;
            return granted(h, s);
         end
         OP_LOOKUP: begin
            if (h[31] || owner_q[s] != h)
               return refused(ERR_NOT_FOUND);
            return granted(h, s);
         end
         default: return refused(ERR_NONE);
      endcase
   endfunction

   function automatic int field_mismatch(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      outcome_t want;
      int       bad;
      bad = 0;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            ring_q[i]  = 6'(i);
            gen_q[i]   = '0;
            owner_q[i] = NONE_HANDLE;
         end
         head_q = '0;
         tail_q = 7'(SLOTS);
         base_q = REGION_BASE_RESET;
         size_q = REGION_SIZE_RESET;
         pending_outcomes.delete();
      end else begin
         if (rsp_valid) begin
            if (pending_outcomes.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, got handle %h",
                        $time, rsp_handle_out);
               bad++;
            end else begin
               want = pending_outcomes.pop_front();
               bad += field_mismatch("ok", want.ok, rsp_ok);
               bad += field_mismatch("error_code", want.error_code, rsp_error_code);
               bad += field_mismatch("handle_out", want.handle, rsp_handle_out);
               bad += field_mismatch("slot_index", want.slot, rsp_slot_index);
               bad += field_mismatch("region_start", want.region_start, rsp_region_start);
               bad += field_mismatch("region_end", want.region_end, rsp_region_end);
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_REGION_BASE: base_q = csr_data;
               CSR_REGION_SIZE: size_q = csr_data;
               default: ;
            endcase
         end
         if (start && !busy)
            pending_outcomes.push_back(apply_request(op_type'(req_opcode), req_handle_in));
      end
      fault_count <= fault_count + bad;
      outstanding <= pending_outcomes.size();
   end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
   import gha_pkg::*;

   localparam int STALL_LIMIT   = 1000;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 90;
   localparam int SETTLE_CYCLES = 16;

   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               start         = 1'b0;
   logic               busy;
   logic [1:0]         req_opcode    = OP_ALLOC;
   logic signed [31:0] req_handle_in = '0;
   logic               rsp_valid;
   logic               rsp_ok;
   logic [2:0]         rsp_error_code;
   logic signed [31:0] rsp_handle_out;
   logic [5:0]         rsp_slot_index;
   logic [31:0]        rsp_region_start;
   logic [31:0]        rsp_region_end;
   logic               csr_we        = 1'b0;
   logic [0:0]         csr_index     = CSR_REGION_BASE;
   logic [31:0]        csr_data      = '0;
   int unsigned        fault_count;
   int unsigned        outstanding;
   int unsigned        stall_cycles  = 0;
   bit                 no_idle       = 1'b0;

   logic [31:0] live_handles    [$];
   logic [31:0] retired_handles [$];
   op_type      issued_ops      [$];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   generational_handle_allocator #(.SLOTS(SLOTS_DEFAULT)) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_handle_in   (req_handle_in),
      .rsp_valid       (rsp_valid),
      .rsp_ok          (rsp_ok),
      .rsp_error_code  (rsp_error_code),
      .rsp_handle_out  (rsp_handle_out),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_region_start(rsp_region_start),
      .rsp_region_end  (rsp_region_end),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   gha_result_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_handle_in   (req_handle_in),
      .rsp_valid       (rsp_valid),
      .rsp_ok          (rsp_ok),
      .rsp_error_code  (rsp_error_code),
      .rsp_handle_out  (rsp_handle_out),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_region_start(rsp_region_start),
      .rsp_region_end  (rsp_region_end),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .fault_count     (fault_count),
      .outstanding     (outstanding)
   );

   // collect granted handles so later frees and lookups can hit live slots
   always @(posedge clock) begin
      op_type op;
      if (!reset && rsp_valid && issued_ops.size() != 0) begin
         op = issued_ops.pop_front();
         if (op == OP_ALLOC && rsp_ok)
            live_handles.push_back(rsp_handle_out);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   task automatic issue(input op_type op, input logic [31:0] h);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_opcode    <= op;
      req_handle_in <= h;
      @(posedge clock);
      while (busy) @(posedge clock);
      issued_ops.push_back(op);
   endtask

   task automatic configure(input logic [31:0] base, input logic [31:0] size);
      csr_we    <= 1'b1;
      csr_index <= CSR_REGION_BASE;
      csr_data  <= base;
      @(posedge clock);
      csr_index <= CSR_REGION_SIZE;
      csr_data  <= size;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // drain every outstanding transaction, then allow for a late early-reject
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_item(input int alloc_w, input int free_w);
      int          pick;
      int          k;
      logic [31:0] h;
      pick = $urandom_range(0, 99);
      h    = $urandom;
      if (pick < alloc_w) begin
         issue(OP_ALLOC, h);
      end else if (pick < alloc_w + free_w) begin
         if (live_handles.size() != 0) begin
            k = $urandom_range(0, live_handles.size() - 1);
            h = live_handles[k];
            live_handles.delete(k);
            retired_handles.push_back(h);
            if (retired_handles.size() > 32)
               retired_handles.delete(0);
         end
         issue(OP_FREE, h);
      end else if (pick < 90) begin
         if (live_handles.size() != 0)
            h = live_handles[$urandom_range(0, live_handles.size() - 1)];
         issue(OP_LOOKUP, h);
      end else begin
         // noise: old handles, forged generations, negatives and no-ops
         case ($urandom_range(0, 4))
            0: if (retired_handles.size() != 0)
                  h = retired_handles[$urandom_range(0, retired_handles.size() - 1)];
            1: if (live_handles.size() != 0)
                  h = live_handles[$urandom_range(0, live_handles.size() - 1)]
                      + 32'd64 * $urandom_range(1, 4);
            2: h[31] = 1'b1;
            default: ;
         endcase
         issue(op_type'($urandom_range(1, 3)), h);
      end
   endtask

   initial begin
      int alloc_w [PHASES] = '{85, 30, 40, 30, 85, 35};
      int free_w  [PHASES] = '{3, 40, 30, 40, 3, 35};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // ring full at reset, unused slots, negatives, stale and double frees
      issue(OP_FREE, 32'h0000_0000);
      issue(OP_LOOKUP, 32'h0000_0000);
      issue(OP_LOOKUP, 32'h8000_0000);
      issue(OP_NOP, $urandom);
      issue(OP_ALLOC, 32'hFFFF_FFFF);
      issue(OP_ALLOC, 32'h0000_0000);
      issue(OP_LOOKUP, 32'h0000_0000);
      issue(OP_LOOKUP, 32'h7FFF_FFFF);
      issue(OP_FREE, 32'hFFFF_FFFF);
      issue(OP_FREE, 32'h8000_0000);
      issue(OP_FREE, 32'h0000_0040);
      issue(OP_FREE, 32'h7FFF_FFC0);
      issue(OP_FREE, 32'h0000_0000);
      issue(OP_FREE, 32'h0000_0000);
      issue(OP_LOOKUP, 32'h0000_0000);
      issue(OP_ALLOC, $urandom);
      issue(OP_FREE, 32'h0000_0001);
      issue(OP_FREE, 32'h0000_0002);
      issue(OP_FREE, 32'h0000_0002);
      issue(OP_NOP, 32'hFFFF_FFFF);
      settle();
      live_handles.delete();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            1: configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
            2: configure(32'h0000_0000, 32'h0000_0000);
            4: configure(32'h8000_0000, 32'h0000_0001);
            3, 5: configure($urandom, $urandom);
            default: ;
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 16 == 0)
               no_idle = ($urandom_range(0, 3) == 0);
            random_item(alloc_w[phase], free_w[phase]);
         end
         settle();
      end

      if (fault_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
